// ===== rtl/core/nct_pkg.sv =====
package nct_pkg;

    // List length and derived widths
    localparam int MAX_SELECT = 64;
    localparam int CNT_W      = $clog2(MAX_SELECT + 1);

    localparam int ROW_W   = 20;
    localparam int VALUE_W = 64;
    localparam int FRAC_W  = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic        [ROW_W-1:0]   row_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [CNT_W-1:0]   count_t;
    typedef logic        [3:0]         mode_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    // condition_mode codes
    localparam mode_t MODE_EQ      = 4'd0;
    localparam mode_t MODE_NEQ     = 4'd1;
    localparam mode_t MODE_LT      = 4'd2;
    localparam mode_t MODE_GT      = 4'd3;
    localparam mode_t MODE_LTE     = 4'd4;
    localparam mode_t MODE_GTE     = 4'd5;
    localparam mode_t MODE_BETWEEN = 4'd6;
    localparam mode_t MODE_TOP     = 4'd7;
    localparam mode_t MODE_BOTTOM  = 4'd8;

    // register indexes
    localparam cfg_idx_t REG_MODE = 2'd0;
    localparam cfg_idx_t REG_LOW  = 2'd1;
    localparam cfg_idx_t REG_HIGH = 2'd2;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

    // broadcast from the controller to every list cell
    typedef struct packed {
        logic   insert;
        logic   shift_up;
        logic   clear;
        logic   top;
        value_t value;
        row_t   row;
    } cell_cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   better;
        value_t value;
        row_t   row;
    } cell_link_t;

endpackage

// ===== rtl/core/nct_if.sv =====
interface nct_cell_if;
    import nct_pkg::*;

    logic   valid;
    logic   ready;
    row_t   row_number;
    value_t cell_value;
    logic   is_numeric;
    logic   last_cell;

    modport source (output valid, row_number, cell_value, is_numeric, last_cell,
                    input ready);
    modport sink   (input valid, row_number, cell_value, is_numeric, last_cell,
                    output ready);
endinterface

interface nct_result_if;
    import nct_pkg::*;

    logic valid;
    logic ready;
    row_t result_row;
    logic passes;
    logic final_result;

    modport source (output valid, result_row, passes, final_result, input ready);
    modport sink   (input valid, result_row, passes, final_result, output ready);
endinterface

interface nct_cfg_if;
    import nct_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    value_t   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/nct_cmp.sv =====
module nct_cmp (
    input  nct_pkg::mode_t  mode,
    input  nct_pkg::value_t thr_low,
    input  nct_pkg::value_t thr_high,
    input  nct_pkg::value_t value,
    input  logic            numeric,
    output logic            pass
);
    import nct_pkg::*;

    logic lt_low;
    logic gt_low;
    logic gt_high;
    logic eq_low;
    logic hit;

    assign lt_low  = value < thr_low;
    assign gt_low  = value > thr_low;
    assign gt_high = value > thr_high;
    assign eq_low  = value == thr_low;

    always_comb
    begin
        case (mode)
            MODE_EQ:      hit = eq_low;
            MODE_NEQ:     hit = !eq_low;
            MODE_LT:      hit = lt_low;
            MODE_GT:      hit = gt_low;
            MODE_LTE:     hit = !gt_low;
            MODE_GTE:     hit = !lt_low;
            MODE_BETWEEN: hit = !lt_low && !gt_high;
            default:      hit = 1'b0;
        endcase
    end

    assign pass = numeric && hit;

endmodule

// ===== rtl/core/nct_cell.sv =====
module nct_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nct_pkg::cell_cmd_t   cmd,
    input  nct_pkg::cell_link_t  prev,
    input  nct_pkg::cell_link_t  next,
    output nct_pkg::cell_link_t  link
);
    import nct_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;
    value_t value_next;
    row_t   row_reg;
    row_t   row_next;
    logic   better;

    // strict compare keeps the earlier of two equal values ahead
    assign better = !valid_reg ||
                    (cmd.top ? (value_reg < cmd.value) : (cmd.value < value_reg));

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        row_next   = row_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.insert)
        begin
            if (prev.better)
            begin
                valid_next = prev.valid;
                value_next = prev.value;
                row_next   = prev.row;
            end
            else if (better)
            begin
                valid_next = 1'b1;
                value_next = cmd.value;
                row_next   = cmd.row;
            end
        end
        else if (cmd.shift_up)
        begin
            valid_next = next.valid;
            value_next = next.value;
            row_next   = next.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        row_reg   <= row_next;
    end

    assign link.valid  = valid_reg;
    assign link.better = better;
    assign link.value  = value_reg;
    assign link.row    = row_reg;

endmodule

// ===== rtl/core/numeric_condition_and_top_k_filter.sv =====
// Numeric condition and top/bottom-N filter.
// cells:   one request per column cell (row_number, cell_value Q32.32,
//          is_numeric, last_cell); taken when valid and ready are high.
// results: result_row, passes, final_result from an output register.
// cfg:     register writes (0 condition_mode, 1 threshold_low,
//          2 threshold_high); always ready, write only while idle.
// Compare modes: one result per cell, registered in the cycle after the
//   request is taken; one cell per cycle while the receiver keeps up.
// Top/bottom modes: each numeric cell enters a chain of MAX_SELECT cells
//   that keeps the list sorted, one cell per cycle while the receiver keeps
//   up, nothing emitted. After the last cell the state moves to drain and
//   the chain shifts to its head, emitting min(N, kept) rows through the
//   output register, one per cycle while it is free; no cell is taken in
//   drain. With nothing selected a single empty final result goes out.
// A stalled receiver holds the output register; a new request is taken
//   only when that register is empty or drains in the same cycle.
// Reset empties the list and the output register and zeroes the config;
//   there is no clearing pass.
module numeric_condition_and_top_k_filter (
    input  logic         clk,
    input  logic         rst_n,
    nct_cell_if.sink     cells,
    nct_result_if.source results,
    nct_cfg_if.sink      cfg
);
    import nct_pkg::*;

    // configuration
    mode_t  mode_reg;
    value_t thr_low_reg;
    value_t thr_high_reg;

    // control
    state_t state_reg;
    state_t state_next;
    count_t kept_reg;
    count_t kept_next;
    count_t remain_reg;
    count_t remain_next;

    // output register
    logic out_valid_reg;
    logic out_valid_next;
    row_t out_row_reg;
    row_t out_row_next;
    logic out_pass_reg;
    logic out_pass_next;
    logic out_final_reg;
    logic out_final_next;
    logic out_load;

    logic       out_free;
    logic       accept;
    logic       list_mode;
    logic       cmp_pass;
    count_t     kept_after;
    count_t     sel_count;
    count_t     emit_count;
    cell_cmd_t  cmd;
    cell_link_t links [MAX_SELECT];
    cell_link_t head_prev;
    cell_link_t tail_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_EQ;
            thr_low_reg  <= '0;
            thr_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODE: mode_reg     <= cfg.data[3:0];
                REG_LOW:  thr_low_reg  <= cfg.data;
                REG_HIGH: thr_high_reg <= cfg.data;
                default:  ;
            endcase
        end
    end

    nct_cmp u_cmp (
        .mode     (mode_reg),
        .thr_low  (thr_low_reg),
        .thr_high (thr_high_reg),
        .value    (cells.cell_value),
        .numeric  (cells.is_numeric),
        .pass     (cmp_pass)
    );

    // N from the integer part of threshold_low, clamped to 0..MAX_SELECT
    always_comb
    begin
        if (thr_low_reg[VALUE_W-1])
            sel_count = '0;
        else if (thr_low_reg[VALUE_W-2:FRAC_W] > (VALUE_W-1-FRAC_W)'(MAX_SELECT))
            sel_count = CNT_W'(MAX_SELECT);
        else
            sel_count = thr_low_reg[FRAC_W+CNT_W-1:FRAC_W];
    end

    assign list_mode  = (mode_reg == MODE_TOP) || (mode_reg == MODE_BOTTOM);
    assign kept_after = (cells.is_numeric && (kept_reg < CNT_W'(MAX_SELECT)))
                      ? kept_reg + CNT_W'(1) : kept_reg;
    assign emit_count = (sel_count < kept_after) ? sel_count : kept_after;

    assign out_free    = !out_valid_reg || results.ready;
    assign cells.ready = (state_reg == ST_RUN) && out_free;
    assign accept      = cells.valid && cells.ready;

    always_comb
    begin
        state_next     = state_reg;
        kept_next      = kept_reg;
        remain_next    = remain_reg;
        out_load       = 1'b0;
        out_row_next   = out_row_reg;
        out_pass_next  = out_pass_reg;
        out_final_next = out_final_reg;
        cmd.insert     = 1'b0;
        cmd.shift_up   = 1'b0;
        cmd.clear      = 1'b0;
        cmd.top        = (mode_reg == MODE_TOP);
        cmd.value      = cells.cell_value;
        cmd.row        = cells.row_number;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (list_mode)
                    begin
                        cmd.insert = cells.is_numeric;
                        kept_next  = kept_after;
                        if (cells.last_cell)
                        begin
                            if (emit_count == '0)
                            begin
                                // nothing selected: one empty final result
                                out_load       = 1'b1;
                                out_row_next   = '0;
                                out_pass_next  = 1'b0;
                                out_final_next = 1'b1;
                                cmd.clear      = 1'b1;
                                kept_next      = '0;
                            end
                            else
                            begin
                                remain_next = emit_count;
                                state_next  = ST_DRAIN;
                            end
                        end
                    end
                    else
                    begin
                        out_load       = 1'b1;
                        out_row_next   = cells.row_number;
                        out_pass_next  = cmp_pass;
                        out_final_next = cells.last_cell;
                        if (cells.last_cell)
                        begin
                            cmd.clear = 1'b1;
                            kept_next = '0;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    // head of the chain goes out, the rest moves up one cell
                    out_load       = 1'b1;
                    out_row_next   = links[0].row;
                    out_pass_next  = 1'b1;
                    out_final_next = (remain_reg == CNT_W'(1));
                    cmd.shift_up   = 1'b1;
                    remain_next    = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        cmd.clear  = 1'b1;
                        kept_next  = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            kept_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kept_reg      <= kept_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg   <= out_row_next;
        out_pass_reg  <= out_pass_next;
        out_final_reg <= out_final_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.result_row   = out_row_reg;
    assign results.passes       = out_pass_reg;
    assign results.final_result = out_final_reg;

    // sorted list: cell 0 holds the best value
    assign head_prev = '0;
    assign tail_next = '0;

    for (genvar i = 0; i < MAX_SELECT; i++)
    begin : g_chain
        nct_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .prev  ((i == 0) ? head_prev : links[(i == 0) ? 0 : i - 1]),
            .next  ((i == MAX_SELECT - 1) ? tail_next
                                          : links[(i == MAX_SELECT - 1) ? i : i + 1]),
            .link  (links[i])
        );
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import nct_pkg::*;

    // Top/bottom codes end at MODE_BOTTOM; everything above acts as an
    // always-fail compare mode.
    localparam mode_t MODE_UNUSED_MAX = 4'hF;

    localparam int ITEM_TARGET = 410;    // request count where random stimulus stops
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;    // idle margin before a config write
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        row_t row;
        logic passes;
        logic fin;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    nct_cell_if   cells_if ();
    nct_result_if results_if ();
    nct_cfg_if    cfg_if ();

    numeric_condition_and_top_k_filter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cells_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the filter: config registers plus the ranked list
    // ------------------------------------------------------------------
    mode_t    cur_mode;
    value_t   cur_low;
    value_t   cur_high;
    value_t   rank_val [MAX_SELECT];
    row_t     rank_row [MAX_SELECT];
    int       rank_len;
    verdict_t verdicts_due [$];

    int mismatches = 0;
    int cells_sent;
    int burst_left;
    bit steady;          // sender offers back to back, no gaps
    bit hold_armed = 1'b0;   // test asks for one long hold-off
    bit hold_used = 1'b0;
    int hold_left = 0;   // receiver hold-off, counted down by the ready process
    int cycle_count = 0;
    int stall_style = 0;

    function automatic logic compare_hit(value_t v);
        case (cur_mode)
            MODE_EQ:      return v == cur_low;
            MODE_NEQ:     return v != cur_low;
            MODE_LT:      return v < cur_low;
            MODE_GT:      return v > cur_low;
            MODE_LTE:     return v <= cur_low;
            MODE_GTE:     return v >= cur_low;
            MODE_BETWEEN: return (v >= cur_low) && (v <= cur_high);
            default:      return 1'b0;
        endcase
    endfunction

    // Insert ahead of the first entry the new value beats; equal values
    // stay behind earlier arrivals. A full list drops its tail.
    function automatic void rank_insert(value_t v, row_t r, bit top);
        int p = 0;
        int i;
        while (p < rank_len && !(top ? (v > rank_val[p]) : (v < rank_val[p])))
            p++;
        if (p >= MAX_SELECT)
            return;
        i = (rank_len < MAX_SELECT) ? rank_len : MAX_SELECT - 1;
        while (i > p)
        begin
            rank_val[i] = rank_val[i-1];
            rank_row[i] = rank_row[i-1];
            i--;
        end
        rank_val[p] = v;
        rank_row[p] = r;
        if (rank_len < MAX_SELECT)
            rank_len++;
    endfunction

    // N: integer part of threshold_low, negative as zero, capped at the list size
    function automatic int select_count();
        int n;
        if (cur_low < 0)
            return 0;
        n = cur_low[63:32];
        return (n > MAX_SELECT) ? MAX_SELECT : n;
    endfunction

    // Queue one expected result behind the pending ones
    function automatic void expect_result(row_t r, logic p, logic f);
        verdict_t item;
        item = '{row: r, passes: p, fin: f};
        verdicts_due = {verdicts_due, item};
    endfunction

    function automatic void predict_cell(row_t r, value_t v, logic num, logic last);
        int n;
        if (cur_mode == MODE_TOP || cur_mode == MODE_BOTTOM)
        begin
            if (num)
                rank_insert(v, r, cur_mode == MODE_TOP);
            if (!last)
                return;
            n = select_count();
            if (n > rank_len)
                n = rank_len;
            rank_len = 0;
            if (n == 0)
                expect_result('0, 1'b0, 1'b1);
            for (int k = 0; k < n; k++)
                expect_result(rank_row[k], 1'b1, k == n - 1);
        end
        else
        begin
            expect_result(r, num && compare_hit(v), last);
            if (last)
                rank_len = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic value_t q(int i);
        return {i, 32'h0};
    endfunction

    // Mix of extremes, small integers and halves (lots of ties) and raw patterns
    function automatic value_t rand_value();
        int s;
        s = int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 9))
            0:          return {1'b1, 63'd0};
            1:          return {1'b0, {63{1'b1}}};
            2:          return '0;
            3, 4, 5, 6: return {s, ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0)};
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    function automatic row_t rand_row();
        return row_t'($urandom);
    endfunction

    // Between bursts the sender sometimes drops valid
    task automatic sender_gap();
        int g;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (g > 0)
        begin
            cells_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // One cell request; prediction happens at the accepting edge
    task automatic send_cell(row_t r, value_t v, logic num, logic last);
        cells_if.valid      <= 1'b1;
        cells_if.row_number <= r;
        cells_if.cell_value <= v;
        cells_if.is_numeric <= num;
        cells_if.last_cell  <= last;
        @(posedge clk);
        while (!cells_if.ready)
            @(posedge clk);
        predict_cell(r, v, num, last);
        cells_sent++;
        if (!steady)
            sender_gap();
    endtask

    task automatic wait_idle();
        cells_if.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg valid high; caller drops it once
    task automatic write_reg(cfg_idx_t idx, value_t d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_MODE: cur_mode = d[3:0];
            REG_LOW:  cur_low  = d;
            REG_HIGH: cur_high = d;
            default: ;
        endcase
    endtask

    task automatic configure(mode_t m, value_t lo, value_t hi);
        value_t mode_word;
        mode_word = {$urandom, $urandom};   // upper bits are don't-care
        if ($urandom_range(0, 1))
            mode_word = '0;
        mode_word[3:0] = m;
        wait_idle();
        write_reg(REG_MODE, mode_word);
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_low(value_t lo);
        wait_idle();
        write_reg(REG_LOW, lo);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: eq against zero
    task automatic run_reset_defaults();
        send_cell('0, '0, 1'b1, 1'b0);
        send_cell({ROW_W{1'b1}}, '0, 1'b0, 1'b0);
    endtask

    task automatic run_compare_modes();
        mode_t m;
        m = MODE_EQ;
        while (m <= MODE_GTE)
        begin
            configure(m, q(3), '0);
            send_cell(rand_row(), q(3), 1'b1, 1'b0);
            send_cell(rand_row(), m[0] ? {1'b0, {63{1'b1}}} : {1'b1, 63'd0}, 1'b1,
                      m == MODE_GTE);
            m = m + 1'b1;
        end
    endtask

    task automatic run_between_and_unused();
        configure(MODE_BETWEEN, q(-2), q(5));
        send_cell(rand_row(), q(-2), 1'b1, 1'b0);
        send_cell(rand_row(), q(5) + 1, 1'b1, 1'b0);
        // inverted window: nothing passes
        configure(MODE_BETWEEN, q(5), q(-2));
        send_cell(rand_row(), q(0), 1'b1, 1'b0);
        configure(MODE_UNUSED_MAX, q(0), q(0));
        send_cell(rand_row(), q(0), 1'b1, 1'b1);
    endtask

    task automatic run_top_bottom_directed();
        // top 3 with a tie (earlier row wins) and a skipped non-numeric cell
        configure(MODE_TOP, {32'd3, 32'hFFFF_FFFF}, '0);
        send_cell(20'd10, q(5), 1'b1, 1'b0);
        send_cell(20'd11, q(7), 1'b1, 1'b0);
        send_cell(20'd12, q(5), 1'b1, 1'b0);
        send_cell(20'd13, q(9), 1'b0, 1'b0);
        send_cell(20'd14, q(1), 1'b1, 1'b1);
        // negative N: empty final result
        configure(MODE_BOTTOM, q(-1), '0);
        send_cell(20'd7, q(2), 1'b1, 1'b1);
        // N far above the list size
        configure(MODE_BOTTOM, q(100), '0);
        send_cell('0, '0, 1'b1, 1'b0);
        send_cell({ROW_W{1'b1}}, {1'b1, 63'd0}, 1'b1, 1'b1);
    endtask

    // Receiver holds off while the sender keeps pushing back to back
    task automatic run_backpressure();
        configure(MODE_GTE, q(0), q(0));
        hold_armed <= 1'b1;
        steady = 1'b1;
        for (int i = 0; i < 40; i++)
            send_cell(rand_row(), rand_value(), $urandom_range(0, 9) != 0, i == 39);
        steady = 1'b0;
    endtask

    task automatic run_random_scans();
        int     len;
        bit     big;
        mode_t  m;
        mode_t  side;
        value_t lo;
        value_t hi;
        while (cells_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                // compare phase, now and then an unused code
                if ($urandom_range(0, 9) == 0)
                    m = mode_t'($urandom_range(MODE_BOTTOM + 1, MODE_UNUSED_MAX));
                else
                    m = mode_t'($urandom_range(MODE_EQ, MODE_BETWEEN));
                configure(m, rand_value(), rand_value());
                len = $urandom_range(5, 25);
                for (int i = 0; i < len; i++)
                    send_cell(rand_row(), rand_value(), $urandom_range(0, 9) != 0,
                              $urandom_range(0, 7) == 0);
            end
            else
            begin
                // ranked scan: mostly short, a few overflow the list
                m   = $urandom_range(0, 1) ? MODE_TOP : MODE_BOTTOM;
                big = ($urandom_range(0, 11) == 0);
                len = big ? $urandom_range(MAX_SELECT + 1, MAX_SELECT + 16)
                          : $urandom_range(1, 16);
                case ($urandom_range(0, 9))
                    0:       lo = {1'b1, 63'($urandom)};
                    1:       lo = {32'($urandom_range(MAX_SELECT + 1, 32'h7FFF_FFFF)), $urandom};
                    default: lo = {32'($urandom_range(0, len + 2)), $urandom};
                endcase
                if (big && $urandom_range(0, 1))
                    lo = q(MAX_SELECT);
                hi = rand_value();
                configure(m, lo, hi);
                for (int i = 0; i < len; i++)
                begin
                    // mid-scan config: new N, or one compare cell, list kept
                    if (i == len / 2 && i > 0 && $urandom_range(0, 3) == 0)
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            set_low({32'($urandom_range(0, len)), $urandom});
                        end
                        else
                        begin
                            lo   = cur_low;
                            side = mode_t'($urandom_range(MODE_EQ, MODE_BETWEEN));
                            configure(side, rand_value(), rand_value());
                            send_cell(rand_row(), rand_value(), 1'b1, 1'b0);
                            configure(m, lo, hi);
                        end
                    end
                    send_cell(rand_row(), rand_value(), $urandom_range(0, 9) != 0,
                              i == len - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: picks a new stall style when the low six bits of cycle_count are zero; a hold-off wins
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            results_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && !hold_used)
        begin
            results_if.ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_used <= 1'b1;
        end
        else
        begin
            if (cycle_count[5:0] == 6'd0)
                stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0:       results_if.ready <= 1'b1;
                1:       results_if.ready <= ($urandom_range(0, 3) != 0);
                2:       results_if.ready <= ($urandom_range(0, 2) == 0);
                default: results_if.ready <= (cycle_count[1:0] != 2'b11);
            endcase
        end
    end

    // Each result request against the oldest pending verdict
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("result_row: no result expected, got %0d", results_if.result_row);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (results_if.result_row !== want.row)
                begin
                    $error("result_row: expected %0d, got %0d", want.row, results_if.result_row);
                    mismatches++;
                end
                if (results_if.passes !== want.passes)
                begin
                    $error("passes: expected %0d, got %0d", want.passes, results_if.passes);
                    mismatches++;
                end
                if (results_if.final_result !== want.fin)
                begin
                    $error("final_result: expected %0d, got %0d", want.fin,
                           results_if.final_result);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cells_if.valid      = 1'b0;
        cells_if.row_number = '0;
        cells_if.cell_value = '0;
        cells_if.is_numeric = 1'b0;
        cells_if.last_cell  = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_MODE;
        cfg_if.data         = '0;
        cur_mode    = MODE_EQ;
        cur_low     = '0;
        cur_high    = '0;
        rank_len    = 0;
        cells_sent  = 0;
        burst_left  = 0;
        steady      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_reset_defaults();
        run_compare_modes();
        run_between_and_unused();
        run_top_bottom_directed();
        run_backpressure();
        run_random_scans();

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
